@@ rtl/core/sfwg_pkg.sv @@
// Shared types and constants of the span fill write generator.
package sfwg_pkg;

	localparam int MAX_SPAN_PIXELS = 40;

	// result status codes
	localparam logic [1:0] ST_WRITE      = 2'd0;
	localparam logic [1:0] ST_FALLBACK   = 2'd1;
	localparam logic [1:0] ST_MISALIGNED = 2'd2;
	localparam logic [1:0] ST_BADCOUNT   = 2'd3;

	// write size codes
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	// depth_mode codes
	localparam logic [1:0] DEPTH_16 = 2'd0;
	localparam logic [1:0] DEPTH_24 = 2'd1;

	// byte_order codes
	localparam logic [1:0] BO_BIG_RGB    = 2'd0;
	localparam logic [1:0] BO_LITTLE_RGB = 2'd1;
	localparam logic [1:0] BO_BIG_BGR    = 2'd2;
	localparam logic [1:0] BO_LITTLE_BGR = 2'd3;

	// config register indexes
	localparam logic [0:0] CFG_DEPTH_MODE = 1'b0;
	localparam logic [0:0] CFG_BYTE_ORDER = 1'b1;

	typedef struct packed {
		logic [31:0] start_addr;
		logic [23:0] fill_color;
		logic [5:0]  pixel_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] write_addr;
		logic [1:0]  write_size;
		logic [31:0] write_data;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STAT,
		S_HEAD,
		S_WORD,
		S_TAIL
	} fsm_state_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_STAT,
		EM_HEAD,
		EM_WORD,
		EM_TAIL
	} emit_t;

	typedef struct packed {
		logic  load;
		emit_t emit;
		logic  last;
	} dp_cmd_t;

	typedef struct packed {
		logic pre_err;
		logic pre_head;
		logic pre_word;
		logic head_last;
		logic word_last;
		logic tail_last;
		logic word_left;
		logic tail_left;
	} dp_stat_t;

endpackage

@@ rtl/core/span_fill_write_generator_core.sv @@
// Top level of the span fill write generator: controller plus datapath.
//
// A span fill request (start byte address, color, pixel count) is taken at a
// clock edge with start high and busy low. The block then puts out the memory
// writes that fill the span, one per cycle on result with result_valid high for
// exactly that cycle; the receiver cannot hold results off, so it must take one
// write every cycle. Writes go in ascending address order: head writes up to
// the next word boundary, whole words, then a tail halfword or tail bytes.
// Requests the block does not handle give a single status result instead.
// The accept cycle itself puts out no result; the state machine then emits one
// write per cycle and goes back to idle with the last one.
// depth_mode and byte_order are written through cfg_we / cfg_index / cfg_data
// and must only change while busy is low.
module span_fill_write_generator_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sfwg_pkg::req_t  request,
	output logic            result_valid,
	output sfwg_pkg::rsp_t  result,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [1:0]      cfg_data
);
	import sfwg_pkg::*;

	dp_cmd_t  cmd;   // controller -> datapath
	dp_stat_t stat;  // datapath -> controller

	// sequencing
	sfwg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	// decode, counters and write data
	sfwg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (request),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

@@ rtl/core/sfwg_ctrl.sv @@
// Sequencing state machine: status, head, word and tail phases.
module sfwg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sfwg_pkg::dp_stat_t stat,
	output sfwg_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              result_valid
);
	import sfwg_pkg::*;

	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = EM_NONE;
		cmd.last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					priority if (stat.pre_err) state_d = S_STAT;
					else if (stat.pre_head) state_d = S_HEAD;
					else if (stat.pre_word) state_d = S_WORD;
					else state_d = S_TAIL;
				end
			end
			S_STAT: begin
				cmd.emit = EM_STAT;
				cmd.last = 1'b1;
				state_d  = S_IDLE;
			end
			S_HEAD: begin
				cmd.emit = EM_HEAD;
				if (stat.head_last) begin
					priority if (stat.word_left) state_d = S_WORD;
					else if (stat.tail_left) state_d = S_TAIL;
					else begin
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_WORD: begin
				cmd.emit = EM_WORD;
				if (stat.word_last) begin
					if (stat.tail_left) begin
						state_d = S_TAIL;
					end else begin
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_TAIL: begin
				cmd.emit = EM_TAIL;
				if (stat.tail_last) begin
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (cmd.emit != EM_NONE);

endmodule

@@ rtl/core/sfwg_datapath.sv @@
// Config registers, request decode, address and item counters, write data.
module sfwg_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [1:0]        cfg_data,
	input  sfwg_pkg::req_t    request,
	input  sfwg_pkg::dp_cmd_t cmd,
	output sfwg_pkg::dp_stat_t stat,
	output sfwg_pkg::rsp_t    result
);
	import sfwg_pkg::*;

	logic [1:0]  depth_q, order_q;

	logic [31:0] addr_q;
	logic [23:0] color_q;
	logic [1:0]  status_q;
	logic        bpp24_q;
	logic [1:0]  head_cnt_q, tail_cnt_q;
	logic [4:0]  word_cnt_q;
	logic [1:0]  hidx_q, tidx_q, pidx_q;

	// request decode
	logic [1:0]  head;
	logic [7:0]  head_x, len2, len3, rem;
	logic        bpp24, bad_cnt, fb16, fb24;
	logic [1:0]  pre_status, pre_head_n, pre_tail_n, tidx_init, pidx_init;
	logic [4:0]  pre_word_n;

	// data generation
	logic [23:0] cp;
	logic        rising;
	logic [31:0] pat_a, pat_b, pat_d, word_data;
	logic [7:0]  rgb_h, rgb_t;
	logic [31:0] step;

	function automatic logic [7:0] rgb_byte(input logic [23:0] c, input logic [1:0] order,
			input logic [1:0] idx);
		logic [7:0] b;
		b = 8'd0;
		unique case (idx)
			2'd0: b = (order == BO_BIG_RGB || order == BO_LITTLE_RGB) ? c[7:0] : c[23:16];
			2'd1: b = c[15:8];
			2'd2: b = (order == BO_BIG_RGB || order == BO_LITTLE_RGB) ? c[23:16] : c[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_16;
			order_q <= BO_BIG_RGB;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEPTH_MODE: depth_q <= cfg_data;
				CFG_BYTE_ORDER: order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode of the incoming request
	always_comb begin
		head    = 2'(~request.start_addr[1:0] + 2'd1);
		head_x  = {6'd0, head};
		len2    = {1'b0, request.pixel_count, 1'b0};
		len3    = len2 + {2'd0, request.pixel_count};
		bpp24   = (depth_q == DEPTH_24);
		rem     = (bpp24 ? len3 : len2) - head_x;
		bad_cnt = (request.pixel_count == 6'd0) ||
			(request.pixel_count > 6'(MAX_SPAN_PIXELS));
		fb16    = (len2 <= head_x);
		fb24    = (len3 < head_x + 8'd12);

		priority if (bad_cnt) pre_status = ST_BADCOUNT;
		else if (depth_q != DEPTH_16 && depth_q != DEPTH_24) pre_status = ST_FALLBACK;
		else if (!bpp24 && request.start_addr[0]) pre_status = ST_MISALIGNED;
		else if (!bpp24 && fb16) pre_status = ST_FALLBACK;
		else if (bpp24 && fb24) pre_status = ST_FALLBACK;
		else pre_status = ST_WRITE;

		pre_head_n = bpp24 ? head : {1'b0, head[1]};
		pre_word_n = rem[6:2];
		pre_tail_n = bpp24 ? rem[1:0] : {1'b0, rem[1]};

		// first tail byte comes from the pixel slot that ends the span
		unique case (rem[1:0])
			2'd1:    tidx_init = 2'd2;
			2'd2:    tidx_init = 2'd1;
			default: tidx_init = 2'd0;
		endcase
		// word pattern phase follows the head byte count
		pidx_init = (head == 2'd3) ? 2'd0 : head;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q     <= request.start_addr;
			color_q    <= request.fill_color;
			status_q   <= pre_status;
			bpp24_q    <= bpp24;
			head_cnt_q <= pre_head_n;
			word_cnt_q <= pre_word_n;
			tail_cnt_q <= pre_tail_n;
			hidx_q     <= 2'd0;
			tidx_q     <= tidx_init;
			pidx_q     <= pidx_init;
		end else begin
			unique case (cmd.emit)
				EM_HEAD: begin
					addr_q     <= addr_q + step;
					head_cnt_q <= head_cnt_q - 2'd1;
					hidx_q     <= hidx_q + 2'd1;
				end
				EM_WORD: begin
					addr_q     <= addr_q + 32'd4;
					word_cnt_q <= word_cnt_q - 5'd1;
					pidx_q     <= (pidx_q == 2'd2) ? 2'd0 : pidx_q + 2'd1;
				end
				EM_TAIL: begin
					addr_q     <= addr_q + step;
					tail_cnt_q <= tail_cnt_q - 2'd1;
					tidx_q     <= (tidx_q == 2'd2) ? 2'd0 : tidx_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.pre_err   = (pre_status != ST_WRITE);
		stat.pre_head  = (pre_head_n != 2'd0);
		stat.pre_word  = (pre_word_n != 5'd0);
		stat.head_last = (head_cnt_q == 2'd1);
		stat.word_last = (word_cnt_q == 5'd1);
		stat.tail_last = (tail_cnt_q == 2'd1);
		stat.word_left = (word_cnt_q != 5'd0);
		stat.tail_left = (tail_cnt_q != 2'd0);
	end

	// address step, 24 bpp word patterns, 16 bpp word data, head and tail bytes
	always_comb begin
		step   = bpp24_q ? 32'd1 : 32'd2;
		cp     = (order_q == BO_BIG_RGB || order_q == BO_LITTLE_BGR) ?
			{color_q[7:0], color_q[15:8], color_q[23:16]} : color_q;
		rising = (order_q == BO_BIG_RGB || order_q == BO_BIG_BGR);
		pat_a  = {cp, cp[23:16]};
		pat_b  = {cp[15:0], cp[23:8]};
		pat_d  = {cp[7:0], cp};
		unique case (pidx_q)
			2'd0:    word_data = rising ? pat_a : pat_d;
			2'd1:    word_data = pat_b;
			2'd2:    word_data = rising ? pat_d : pat_a;
			default: word_data = pat_b;
		endcase
		if (!bpp24_q) begin
			word_data = {color_q[15:0], color_q[15:0]};
		end
		rgb_h = rgb_byte(color_q, order_q, hidx_q);
		rgb_t = rgb_byte(color_q, order_q, tidx_q);
	end

	always_comb begin
		result.status     = ST_WRITE;
		result.write_addr = addr_q;
		result.write_size = bpp24_q ? SZ_BYTE : SZ_HALF;
		result.write_data = 32'd0;
		result.last       = cmd.last;
		unique case (cmd.emit)
			EM_STAT: begin
				result.status     = status_q;
				result.write_addr = 32'd0;
				result.write_size = SZ_BYTE;
			end
			EM_HEAD: begin
				result.write_data = bpp24_q ? {24'd0, rgb_h} : {16'd0, color_q[15:0]};
			end
			EM_WORD: begin
				result.write_size = SZ_WORD;
				result.write_data = word_data;
			end
			EM_TAIL: begin
				result.write_data = bpp24_q ? {24'd0, rgb_t} : {16'd0, color_q[15:0]};
			end
			default: ;
		endcase
	end

endmodule

@@ tb/tb_span_fill_write_generator_core.sv @@
// Self-checking testbench for the span fill write generator core.
`timescale 1ns / 100ps

module tb_span_fill_write_generator_core;
	import sfwg_pkg::*;

	// depth codes with no name in the package: both are never handled
	localparam logic [1:0] DEPTH_32     = 2'd2;
	localparam logic [1:0] DEPTH_UNUSED = 2'd3;

	// cycles with no request taken and no result seen before giving up;
	// the longest legal quiet stretch is a short sender gap or an idle drain
	localparam int STALL_LIMIT = 2000;
	// cycles to keep watching after the last expected write has shown up
	localparam int TAIL_CYCLES = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       request = '0;
	logic       result_valid;
	rsp_t       result;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_DEPTH_MODE;
	logic [1:0] cfg_data = DEPTH_16;

	// local copy of the two config registers, as the block should hold them
	logic [1:0] depth_mode_q = DEPTH_16;
	logic [1:0] byte_order_q = BO_BIG_RGB;

	// writes predicted for accepted requests, oldest first
	rsp_t expected_writes [$];
	rsp_t oldest_write;

	int error_count = 0;
	int requests_sent = 0;
	int writes_seen = 0;
	int status_seen = 0;
	int stall_cycles = 0;
	int idle_pct = 8;

	span_fill_write_generator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Write predictor
	// ------------------------------------------------------------------

	function automatic void push_write(input logic [1:0] st, input logic [31:0] addr,
			input logic [1:0] size, input logic [31:0] data);
		rsp_t w;
		w.status     = st;
		w.write_addr = addr;
		w.write_size = size;
		w.write_data = data;
		w.last       = 1'b0;
		expected_writes.push_back(w);
	endfunction

	// Expands one span request into the writes the block must emit, using the
	// register values in force when it is accepted.
	function automatic void predict_span_writes(input req_t rq);
		logic [31:0] addr;
		logic [23:0] col;
		logic [23:0] base;
		logic [15:0] c16;
		logic [7:0]  rgb [3];
		logic [31:0] pat [3];
		logic [31:0] wpat [3];
		logic [1:0]  st;
		logic        rising;
		rsp_t        tail;
		int          cnt;
		int          head;
		int          len;
		int          nwords;
		int          tl;

		addr = rq.start_addr;
		col  = rq.fill_color;
		cnt  = int'(rq.pixel_count);
		head = (4 - int'(addr[1:0])) % 4;

		// the checks run in a fixed order: count first, then depth, then
		// the per-depth alignment and length limits
		st = ST_WRITE;
		if (cnt == 0 || cnt > MAX_SPAN_PIXELS)
			st = ST_BADCOUNT;
		else if (!(depth_mode_q == DEPTH_16 || depth_mode_q == DEPTH_24))
			st = ST_FALLBACK;
		else if (depth_mode_q == DEPTH_16) begin
			if (addr[0])
				st = ST_MISALIGNED;
			else if (cnt * 2 <= head)
				st = ST_FALLBACK;   // the head halfword eats the whole span
		end else if (cnt * 3 < head + 12)
			st = ST_FALLBACK;       // 24 bpp needs a full block after the head

		if (st != ST_WRITE)
			push_write(st, 32'h0, SZ_BYTE, 32'h0);
		else if (depth_mode_q == DEPTH_16) begin
			c16 = col[15:0];
			len = cnt * 2 - head;
			for (int i = 0; i < head / 2; i++) begin
				push_write(ST_WRITE, addr, SZ_HALF, {16'h0, c16});
				addr += 32'd2;
			end
			// 4-word blocks plus tail words collapse to len / 4 words
			nwords = len / 4;
			tl = (len % 4) / 2;
			for (int i = 0; i < nwords; i++) begin
				push_write(ST_WRITE, addr, SZ_WORD, {c16, c16});
				addr += 32'd4;
			end
			for (int i = 0; i < tl; i++) begin
				push_write(ST_WRITE, addr, SZ_HALF, {16'h0, c16});
				addr += 32'd2;
			end
		end else begin
			len = cnt * 3 - head;
			if (byte_order_q == BO_BIG_RGB || byte_order_q == BO_LITTLE_RGB) begin
				rgb[0] = col[7:0];
				rgb[1] = col[15:8];
				rgb[2] = col[23:16];
			end else begin
				rgb[0] = col[23:16];
				rgb[1] = col[15:8];
				rgb[2] = col[7:0];
			end
			// RGB big and BGR little build the words from the R/B swapped color
			if (byte_order_q == BO_LITTLE_RGB || byte_order_q == BO_BIG_BGR)
				base = col;
			else
				base = {col[7:0], col[15:8], col[23:16]};
			rising = (byte_order_q == BO_BIG_RGB || byte_order_q == BO_BIG_BGR);
			pat[0] = rising ? {base, base[23:16]} : {base[7:0], base};
			pat[1] = {base[15:0], base[23:8]};
			pat[2] = rising ? {base[7:0], base} : {base, base[23:16]};
			// the head length sets where the 12-byte pattern starts
			for (int j = 0; j < 3; j++)
				wpat[j] = pat[(head + j) % 3];
			for (int i = 0; i < head; i++) begin
				push_write(ST_WRITE, addr, SZ_BYTE, {24'h0, rgb[i]});
				addr += 32'd1;
			end
			nwords = len / 4;
			tl = len % 4;
			for (int i = 0; i < nwords; i++) begin
				push_write(ST_WRITE, addr, SZ_WORD, wpat[i % 3]);
				addr += 32'd4;
			end
			for (int i = 0; i < tl; i++) begin
				push_write(ST_WRITE, addr, SZ_BYTE, {24'h0, rgb[(3 - tl + i) % 3]});
				addr += 32'd1;
			end
		end

		tail = expected_writes[expected_writes.size() - 1];
		tail.last = 1'b1;
		expected_writes[expected_writes.size() - 1] = tail;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// results cannot be held off, so every strobe is taken at this edge
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_writes.size() == 0) begin
				$display({"%0t: unexpected result: expected none, ",
					"got st=%0d addr=%h size=%0d data=%h last=%0b"},
					$time, result.status, result.write_addr, result.write_size,
					result.write_data, result.last);
				error_count++;
			end else begin
				oldest_write = expected_writes.pop_front();
				compare_field("status", 32'(oldest_write.status), 32'(result.status));
				compare_field("write_addr", oldest_write.write_addr, result.write_addr);
				compare_field("write_size", 32'(oldest_write.write_size),
					32'(result.write_size));
				compare_field("write_data", oldest_write.write_data, result.write_data);
				compare_field("last", 32'(oldest_write.last), 32'(result.last));
				if (oldest_write.status == ST_WRITE)
					writes_seen++;
				else
					status_seen++;
			end
		end
	end

	// watchdog: only counts cycles where neither a request nor a result moves
	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d writes outstanding",
				$time, stall_cycles, expected_writes.size());
			$display("tb_span_fill_write_generator_core: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offers one request, dropping start on random cycles, and books its
	// writes once the block takes it. start is left high on return so that
	// back-to-back requests need no low cycle.
	task automatic issue_span(input req_t item);
		bit taken;
		taken = 1'b0;
		request <= item;
		while (!taken) begin
			if ($urandom_range(99) < idle_pct)
				start <= 1'b0;
			else
				start <= 1'b1;
			@(posedge clk);
			if (start && !busy)
				taken = 1'b1;
		end
		predict_span_writes(item);
		requests_sent++;
	endtask

	task automatic issue_fields(input logic [31:0] addr, input logic [23:0] col,
			input logic [5:0] cnt);
		req_t rq;
		rq.start_addr  = addr;
		rq.fill_color  = col;
		rq.pixel_count = cnt;
		issue_span(rq);
	endtask

	// waits until every booked write is back and the block is idle
	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_writes.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// both registers, one per cycle; only called while idle
	task automatic write_config(input logic [1:0] depth, input logic [1:0] order);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEPTH_MODE;
		cfg_data  <= depth;
		@(posedge clk);
		depth_mode_q = depth;
		cfg_index <= CFG_BYTE_ORDER;
		cfg_data  <= order;
		@(posedge clk);
		byte_order_q = order;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_t random_span(input logic [1:0] depth);
		req_t rq;
		int   pick;
		rq.start_addr = $urandom;
		rq.fill_color = 24'($urandom);
		if ($urandom_range(99) < 5)
			rq.start_addr = 32'hFFFF_FFC0 | $urandom_range(63);   // wraps past the top
		if (depth == DEPTH_16 && $urandom_range(9) != 0)
			rq.start_addr[0] = 1'b0;
		pick = $urandom_range(99);
		if (pick < 4)
			rq.pixel_count = 6'd0;
		else if (pick < 12)
			rq.pixel_count = 6'($urandom_range(63, MAX_SPAN_PIXELS + 1));
		else
			rq.pixel_count = 6'($urandom_range(MAX_SPAN_PIXELS, 1));
		return rq;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// registers untouched: the block must come out of reset at 16 bpp
	task automatic test_reset_defaults();
		issue_fields(32'h0000_0010, 24'h001234, 6'd9);
		issue_fields(32'h0000_0006, 24'hFEDCBA, 6'd17);
		wait_idle();
	endtask

	task automatic test_depth16_directed();
		write_config(DEPTH_16, BO_BIG_RGB);
		issue_fields(32'h0000_0000, 24'hFFFFFF, 6'd40);   // aligned, longest span
		issue_fields(32'h0000_0102, 24'h00ABCD, 6'd1);    // head halfword eats the span: fallback
		issue_fields(32'h0000_0102, 24'h000000, 6'd2);    // head half plus tail half
		issue_fields(32'h0000_0100, 24'h005A5A, 6'd1);    // single tail halfword
		issue_fields(32'h0000_0201, 24'h0F0F0F, 6'd5);    // odd start
		issue_fields(32'hFFFF_FFFF, 24'h800000, 6'd3);    // odd start at the top
		issue_fields(32'h0000_0003, 24'h123456, 6'd0);    // count check wins over alignment
		issue_fields(32'h0000_0040, 24'h654321, 6'd41);
		issue_fields(32'h0000_0080, 24'h111111, 6'd63);
		issue_fields(32'hFFFF_FFF2, 24'h00FFFF, 6'd30);   // address wraps
		wait_idle();
	endtask

	task automatic test_depth24_directed();
		logic [1:0] orders [4];
		orders = '{BO_BIG_RGB, BO_LITTLE_RGB, BO_BIG_BGR, BO_LITTLE_BGR};
		idle_pct = 0;
		// each order starts at a different head length
		for (int k = 0; k < 4; k++) begin
			write_config(DEPTH_24, orders[k]);
			issue_fields(32'h0000_2000 + k, 24'hA1B2C3, 6'(MAX_SPAN_PIXELS - k));
			wait_idle();
		end
		issue_fields(32'h0000_3000, 24'h00FF00, 6'd4);    // exactly one block, no head
		issue_fields(32'h0000_3001, 24'hFF00FF, 6'd4);    // one block short after head
		issue_fields(32'h0000_3003, 24'h010203, 6'd5);    // just enough after one head byte
		issue_fields(32'h0000_3004, 24'h7F7F7F, 6'd0);
		issue_fields(32'hFFFF_FFFD, 24'hFFFFFF, 6'd40);   // wraps mid span
		wait_idle();
		idle_pct = 8;
	endtask

	task automatic test_unhandled_depth();
		write_config(DEPTH_32, BO_LITTLE_BGR);
		issue_fields(32'h0000_0000, 24'hFFFFFF, 6'd40);
		issue_fields(32'h0000_0001, 24'h000000, 6'd0);    // bad count still reported first
		wait_idle();
		write_config(DEPTH_UNUSED, BO_BIG_RGB);
		issue_fields(32'h0000_0003, 24'h123456, 6'd20);
		wait_idle();
	endtask

	// phases of random requests, one register setting each; one phase runs
	// with the sender never idling
	task automatic test_random_spans();
		logic [1:0] phase_depth [9];
		logic [1:0] phase_order [9];
		int         phase_items [9];
		phase_depth = '{DEPTH_16, DEPTH_24, DEPTH_24, DEPTH_24, DEPTH_24,
			DEPTH_32, DEPTH_UNUSED, DEPTH_24, DEPTH_16};
		phase_order = '{BO_LITTLE_BGR, BO_BIG_RGB, BO_LITTLE_RGB, BO_BIG_BGR,
			BO_LITTLE_BGR, BO_BIG_RGB, BO_LITTLE_RGB, BO_BIG_RGB, BO_BIG_RGB};
		phase_items = '{40, 30, 30, 30, 30, 8, 6, 30, 30};
		for (int p = 0; p < 9; p++) begin
			if (p == 7)
				phase_order[p] = 2'($urandom_range(3));
			write_config(phase_depth[p], phase_order[p]);
			idle_pct = (p == 1) ? 0 : 8;
			for (int n = 0; n < phase_items[p]; n++)
				issue_span(random_span(phase_depth[p]));
			wait_idle();
		end
		idle_pct = 8;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_depth16_directed();
		test_depth24_directed();
		test_unhandled_depth();
		test_random_spans();

		// drain, then keep watching for stray results
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_writes.size() != 0) begin
			$display("%0t: %0d expected writes never arrived", $time, expected_writes.size());
			error_count++;
		end

		$display("Covered %0d span requests at 16, 24 and unhandled depths, all byte orders",
			requests_sent);
		$display("Checked %0d memory writes and %0d status results, %0d mismatches",
			writes_seen, status_seen, error_count);
		if (error_count == 0)
			$display("tb_span_fill_write_generator_core: clean");
		else
			$display("tb_span_fill_write_generator_core: errors");
		$finish;
	end

endmodule

@@ span_fill_write_generator_core.f @@
rtl/core/sfwg_pkg.sv
rtl/core/sfwg_ctrl.sv
rtl/core/sfwg_datapath.sv
rtl/core/span_fill_write_generator_core.sv
tb/tb_span_fill_write_generator_core.sv
